// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Depends on nothing; each use takes its clock and reset from the signals clk and rst_n in its scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside of reset
`define KFLR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a trigger is followed by a consequence in the next cycle
`define KFLR_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/kflr_pkg.sv =====
// Shared types and constants for the keyframe linear reduction block.
// Depends on nothing.
package kflr_pkg;

    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int TIME_W    = 32;
    localparam int TOL_W     = 31;
    localparam int PROD_W    = 2 * COORD_W;
    localparam int REM_W     = 36;
    localparam int CNT_W     = 6;
    localparam int DIV_STEPS  = 31;
    localparam int SQRT_STEPS = 32;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(((1 << FRAC_BITS) + 500) / 1000);

    // Configuration register indexes
    localparam logic [1:0] REG_TRANS_TOL = 2'd0;
    localparam logic [1:0] REG_SCALE_TOL = 2'd1;

    typedef struct packed {
        logic                      channel_kind;
        logic [TIME_W-1:0]         key_time;
        logic signed [COORD_W-1:0] vec_x;
        logic signed [COORD_W-1:0] vec_y;
        logic signed [COORD_W-1:0] vec_z;
        logic                      track_last;
    } in_t;

    typedef struct packed {
        logic [TIME_W-1:0]         kept_time_out;
        logic signed [COORD_W-1:0] kept_x_out;
        logic signed [COORD_W-1:0] kept_y_out;
        logic signed [COORD_W-1:0] kept_z_out;
        logic                      ends_track;
        logic                      run_last;
    } out_t;

    // Results produced by one request, handed to the result queue at once
    typedef struct packed {
        logic       valid;
        logic [1:0] count;
        out_t       res0;
        out_t       res1;
    } emit_t;

    typedef enum logic {
        MODE_DIV,
        MODE_SQRT
    } unit_mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_LMUL,
        ST_LADD,
        ST_SMUL,
        ST_SACC,
        ST_RSTART,
        ST_ROOT,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/core/keyframe_linear_reduction.sv =====
// Keyframe reduction by linear interpolation for 3-vector tracks. Takes one key per
// request, holds the last kept key and one pending key, and emits at most two kept keys
// per request. A request that opens a track, meets no pending key, or has a zero or
// negative time span goes straight to emitting its results. One that tests a pending key
// keeps it busy for the division, if the time ratio needs one, then the interpolation
// and two magnitudes, paced by the one-bit-per-cycle shift-subtract unit (31 steps for
// the interpolation factor, 32 steps for each of the two magnitudes) and by the shared
// 32x32 multiplier (nine products: three for the interpolation, six for the magnitudes).
// A new request is taken only once the previous request's results have all been taken.
// Depends on kflr_pkg, kflr_ctrl.
module keyframe_linear_reduction
    import kflr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_t               in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output out_t              out_data,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [TOL_W-1:0]  cfg_data
);

    logic [TOL_W-1:0] trans_tol_reg;
    logic [TOL_W-1:0] scale_tol_reg;
    out_t             q0_reg;
    out_t             q1_reg;
    logic [1:0]       qcnt_reg;
    logic             busy;
    emit_t            emit;
    logic             in_take;
    logic             out_take;

    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid && !out_stall;

    kflr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_take),
        .item      (in_data),
        .trans_tol (trans_tol_reg),
        .scale_tol (scale_tol_reg),
        .busy      (busy),
        .emit      (emit)
    );

    // Tolerance registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trans_tol_reg <= TOL_RESET;
            scale_tol_reg <= TOL_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_TRANS_TOL)
                trans_tol_reg <= cfg_data;
            else if (cfg_index == REG_SCALE_TOL)
                scale_tol_reg <= cfg_data;
        end
    end

    // Result queue: load both results of a request, drain one per taken result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qcnt_reg <= '0;
        end
        else if (emit.valid)
        begin
            qcnt_reg <= emit.count;
        end
        else if (out_take)
        begin
            qcnt_reg <= qcnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            q0_reg <= emit.res0;
            q1_reg <= emit.res1;
        end
        else if (out_take)
        begin
            q0_reg <= q1_reg;
        end
    end

    assign in_stall  = busy || (qcnt_reg != '0);
    assign out_valid = (qcnt_reg != '0);
    assign out_data  = q0_reg;

endmodule

// ===== rtl/core/kflr_shsub.sv =====
// Shared shift-subtract unit: restoring division and integer square root,
// one bit per cycle. Depends on kflr_pkg.
module kflr_shsub
    import kflr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  unit_mode_t          mode,
    input  logic [PROD_W-1:0]   op_a,
    input  logic [COORD_W-1:0]  op_b,
    output logic                done,
    output logic [COORD_W-1:0]  result
);

    unit_mode_t          mode_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [PROD_W-1:0]   rad_reg;
    logic [COORD_W-1:0]  root_reg;
    logic [COORD_W-1:0]  div_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                done_reg;

    logic [REM_W-1:0]    trial_a;
    logic [REM_W-1:0]    trial_b;
    logic [REM_W:0]      diff;
    logic                ge;

    // Form the shifted remainder and the value to subtract for one step
    always_comb
    begin
        if (mode_reg == MODE_DIV)
        begin
            trial_a = {rem_reg[REM_W-2:0], 1'b0};
            trial_b = {{(REM_W-COORD_W){1'b0}}, div_reg};
        end
        else
        begin
            trial_a = {rem_reg[REM_W-3:0], rad_reg[PROD_W-1 -: 2]};
            trial_b = {{(REM_W-COORD_W-2){1'b0}}, root_reg, 2'b01};
        end
        diff = {1'b0, trial_a} - {1'b0, trial_b};
        ge   = !diff[REM_W];
    end

    // Load on start, then advance one bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= (mode == MODE_DIV) ? CNT_W'(DIV_STEPS) : CNT_W'(SQRT_STEPS);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg  <= cnt_reg - 1'b1;
                done_reg <= (cnt_reg == CNT_W'(1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mode_reg <= mode;
            rem_reg  <= (mode == MODE_DIV) ? {{(REM_W-COORD_W){1'b0}}, op_a[COORD_W-1:0]}
                                           : '0;
            rad_reg  <= op_a;
            root_reg <= '0;
            div_reg  <= op_b;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg  <= ge ? diff[REM_W-1:0] : trial_a;
            root_reg <= {root_reg[COORD_W-2:0], ge};
            rad_reg  <= {rad_reg[PROD_W-3:0], 2'b00};
        end
    end

    assign done   = done_reg;
    assign result = root_reg;

endmodule

// ===== rtl/core/kflr_ctrl.sv =====
// Sequencer and datapath: holds anchor and pending keys, tests the pending key
// with a shared multiplier and the shift-subtract unit. Depends on kflr_pkg, kflr_shsub.
module kflr_ctrl
    import kflr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  in_t               item,
    input  logic [TOL_W-1:0]  trans_tol,
    input  logic [TOL_W-1:0]  scale_tol,
    output logic              busy,
    output emit_t             emit
);

    state_t state_reg;
    state_t state_next;

    in_t                       item_reg;
    logic                      track_open_reg;
    logic                      pending_valid_reg;
    logic [TIME_W-1:0]         anchor_time_reg;
    logic signed [COORD_W-1:0] anchor_vec_reg [3];
    logic [TIME_W-1:0]         pending_time_reg;
    logic signed [COORD_W-1:0] pending_vec_reg [3];

    logic                      test_reg;
    logic                      keep_reg;
    logic [COORD_W-1:0]        alpha_reg;
    logic [1:0]                comp_reg;
    logic                      set_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic [PROD_W-1:0]         sum_reg;
    logic [COORD_W-1:0]        imag_reg [3];
    logic [COORD_W-1:0]        ma_reg;

    logic signed [COORD_W-1:0] next_vec [3];
    logic signed [COORD_W-1:0] nv;
    logic signed [COORD_W-1:0] av;
    logic signed [COORD_W-1:0] pv;
    logic [COORD_W:0]          d;
    logic [COORD_W:0]          m;
    logic [PROD_W-1:0]         rnd;
    logic [COORD_W+1:0]        step;
    logic [COORD_W+1:0]        av_ext;
    logic [COORD_W+1:0]        interp;
    logic [COORD_W+1:0]        interp_abs;
    logic [COORD_W-1:0]        pabs;
    logic [COORD_W-1:0]        sq_op;
    logic [COORD_W-1:0]        mul_a;
    logic [COORD_W-1:0]        mul_b;

    logic [TIME_W:0]           den;
    logic [TIME_W:0]           num;
    logic                      do_test;
    logic                      den_pos;
    logic                      num_pos;
    logic                      num_ge_den;

    logic                      unit_start;
    unit_mode_t                unit_mode;
    logic [PROD_W-1:0]         unit_a;
    logic [COORD_W-1:0]        unit_b;
    logic                      unit_done;
    logic [COORD_W-1:0]        unit_res;
    logic [COORD_W-1:0]        drift;
    logic                      over_tol;
    logic                      keep_now;

    kflr_shsub u_shsub (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (unit_start),
        .mode   (unit_mode),
        .op_a   (unit_a),
        .op_b   (unit_b),
        .done   (unit_done),
        .result (unit_res)
    );

    // Time spans and the checks that pick the interpolation factor
    always_comb
    begin
        den        = {1'b0, item_reg.key_time} - {1'b0, anchor_time_reg};
        num        = {1'b0, pending_time_reg} - {1'b0, anchor_time_reg};
        do_test    = track_open_reg && pending_valid_reg;
        den_pos    = !den[TIME_W] && (den != '0);
        num_pos    = !num[TIME_W] && (num != '0);
        num_ge_den = num[TIME_W-1:0] >= den[TIME_W-1:0];
    end

    // Per-component interpolation and magnitude operands
    always_comb
    begin
        next_vec[0] = item_reg.vec_x;
        next_vec[1] = item_reg.vec_y;
        next_vec[2] = item_reg.vec_z;
        nv = next_vec[comp_reg];
        av = anchor_vec_reg[comp_reg];
        pv = pending_vec_reg[comp_reg];
        d  = {nv[COORD_W-1], nv} - {av[COORD_W-1], av};
        m  = d[COORD_W] ? ((COORD_W+1)'(0) - d) : d;
        rnd  = prod_reg + (PROD_W'(1) << 30);
        step = {1'b0, rnd[PROD_W-1:31]}
             + (m[COORD_W] ? {1'b0, alpha_reg, 1'b0} : (COORD_W+2)'(0));
        av_ext     = {{2{av[COORD_W-1]}}, av};
        interp     = d[COORD_W] ? (av_ext - step) : (av_ext + step);
        interp_abs = interp[COORD_W+1] ? ((COORD_W+2)'(0) - interp) : interp;
        pabs  = pv[COORD_W-1] ? (COORD_W'(0) - pv) : pv;
        sq_op = set_reg ? imag_reg[comp_reg] : pabs;
        drift = (ma_reg > unit_res) ? (ma_reg - unit_res) : (unit_res - ma_reg);
        over_tol = drift > {1'b0, item_reg.channel_kind ? scale_tol : trans_tol};
        keep_now = test_reg && keep_reg;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (!do_test || !den_pos)
                    state_next = ST_DONE;
                else if (!num_pos || num_ge_den)
                    state_next = ST_LMUL;
                else
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (unit_done)
                    state_next = ST_LMUL;
            end
            ST_LMUL:
                state_next = ST_LADD;
            ST_LADD:
                state_next = (comp_reg == 2'd2) ? ST_SMUL : ST_LMUL;
            ST_SMUL:
                state_next = ST_SACC;
            ST_SACC:
                state_next = (comp_reg == 2'd2) ? ST_RSTART : ST_SMUL;
            ST_RSTART:
                state_next = ST_ROOT;
            ST_ROOT:
            begin
                if (unit_done)
                    state_next = set_reg ? ST_DONE : ST_SMUL;
            end
            ST_DONE:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs: unit requests, multiplier operands, emitted results
    always_comb
    begin
        unit_start = 1'b0;
        unit_mode  = MODE_DIV;
        unit_a     = {{(PROD_W-COORD_W){1'b0}}, num[COORD_W-1:0]};
        unit_b     = den[COORD_W-1:0];
        mul_a      = sq_op;
        mul_b      = sq_op;
        emit       = '0;
        case (state_reg)
            ST_EVAL:
                unit_start = do_test && den_pos && num_pos && !num_ge_den;
            ST_LMUL:
            begin
                mul_a = m[COORD_W-1:0];
                mul_b = alpha_reg;
            end
            ST_RSTART:
            begin
                unit_start = 1'b1;
                unit_mode  = MODE_SQRT;
                unit_a     = sum_reg;
            end
            ST_DONE:
            begin
                emit.valid = 1'b1;
                if (!track_open_reg)
                begin
                    emit.count = 2'd1;
                    emit.res0  = '{item_reg.key_time, item_reg.vec_x, item_reg.vec_y,
                                   item_reg.vec_z, item_reg.track_last, 1'b1};
                end
                else
                begin
                    emit.count = 2'(keep_now) + 2'(item_reg.track_last);
                    if (keep_now)
                    begin
                        emit.res0 = '{pending_time_reg, pending_vec_reg[0],
                                      pending_vec_reg[1], pending_vec_reg[2], 1'b0,
                                      !item_reg.track_last};
                        emit.res1 = '{item_reg.key_time, item_reg.vec_x, item_reg.vec_y,
                                      item_reg.vec_z, 1'b1, 1'b1};
                    end
                    else
                    begin
                        emit.res0 = '{item_reg.key_time, item_reg.vec_x, item_reg.vec_y,
                                      item_reg.vec_z, 1'b1, 1'b1};
                    end
                end
            end
            default:
            begin
                unit_start = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            track_open_reg    <= 1'b0;
            pending_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DONE)
            begin
                if (!track_open_reg)
                begin
                    if (!item_reg.track_last)
                    begin
                        track_open_reg    <= 1'b1;
                        pending_valid_reg <= 1'b0;
                    end
                end
                else if (item_reg.track_last)
                begin
                    track_open_reg    <= 1'b0;
                    pending_valid_reg <= 1'b0;
                end
                else
                begin
                    pending_valid_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    item_reg <= item;
            end
            ST_EVAL:
            begin
                test_reg  <= do_test;
                keep_reg  <= !den_pos;
                alpha_reg <= (num_pos && num_ge_den) ? (COORD_W'(1) << 31) : '0;
                comp_reg  <= '0;
                set_reg   <= 1'b0;
                sum_reg   <= '0;
            end
            ST_DIV:
            begin
                if (unit_done)
                    alpha_reg <= unit_res;
            end
            ST_LADD:
            begin
                imag_reg[comp_reg] <= interp_abs[COORD_W-1:0];
                comp_reg <= (comp_reg == 2'd2) ? 2'd0 : comp_reg + 2'd1;
            end
            ST_SACC:
            begin
                sum_reg  <= sum_reg + prod_reg;
                comp_reg <= (comp_reg == 2'd2) ? 2'd0 : comp_reg + 2'd1;
            end
            ST_ROOT:
            begin
                if (unit_done)
                begin
                    if (!set_reg)
                    begin
                        ma_reg  <= unit_res;
                        set_reg <= 1'b1;
                        sum_reg <= '0;
                    end
                    else
                    begin
                        keep_reg <= over_tol;
                    end
                end
            end
            ST_DONE:
            begin
                if (!track_open_reg)
                begin
                    anchor_time_reg   <= item_reg.key_time;
                    anchor_vec_reg[0] <= item_reg.vec_x;
                    anchor_vec_reg[1] <= item_reg.vec_y;
                    anchor_vec_reg[2] <= item_reg.vec_z;
                end
                else
                begin
                    if (keep_now)
                    begin
                        anchor_time_reg <= pending_time_reg;
                        anchor_vec_reg  <= pending_vec_reg;
                    end
                    if (!item_reg.track_last)
                    begin
                        pending_time_reg   <= item_reg.key_time;
                        pending_vec_reg[0] <= item_reg.vec_x;
                        pending_vec_reg[1] <= item_reg.vec_y;
                        pending_vec_reg[2] <= item_reg.vec_z;
                    end
                end
            end
            default:
            begin
                comp_reg <= comp_reg;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== rtl/core/kflr_checker.sv =====
// Port-level checks for keyframe_linear_reduction, bound to the top level.
// Depends on kflr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kflr_checker
    import kflr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic              out_valid,
    input  logic              out_stall,
    input  out_t              out_data
);

    // A stalled result holds
    `KFLR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

    // An accepted request keeps the block busy in the next cycle
    `KFLR_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "request taken back to back")

    // No request is taken while results wait
    `KFLR_ASSERT(a_no_take_while_out, out_valid |-> in_stall, "request taken with results pending")

    // The final result of a request drains the queue
    `KFLR_ASSERT_NEXT(a_last_drains, out_valid && !out_stall && out_data.run_last, !out_valid, "result after final result")

endmodule

bind keyframe_linear_reduction kflr_checker u_kflr_checker (.*);
